/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the rank fusion datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RFK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rank fusion assertion failed");

// next-cycle implication
`define RFK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rank fusion assertion failed");

`endif

/* rtl/rfk_pkg.sv */
// ----------------------------------------------------------------------------
// rfk_pkg
// shared types, codes and constants of the rank fusion top-k block
// ----------------------------------------------------------------------------
package rfk_pkg;

    localparam int KEY_W      = 64;
    localparam int SCORE_W    = 48;
    localparam int SRC_W      = 3;
    localparam int RANK_W     = 10;
    localparam int HSCORE_W   = 16;
    localparam int WGT_W      = 16;
    localparam int LIM_W      = 7;
    localparam int STRAT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_DOCS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 24;
    localparam int OUT_LIMIT     = 64;

    // divider widths cover every strategy at the default fraction width
    localparam int DIV_W = 48;
    localparam int DEN_W = 26;

    localparam int RANK_BIAS  = 60;
    localparam int BORDA_BASE = 100;
    localparam int ONE_Q15    = 32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_TEXT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_PATH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_SYMBOL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W_GRAPH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_W_VECTOR  = 3'd6;

    // strategies
    localparam logic [STRAT_W-1:0] STRAT_WSUM   = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_RRANK  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_BORDA  = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_WRECIP = 2'd3;

    // sources
    localparam logic [SRC_W-1:0] SRC_TEXT   = 3'd0;
    localparam logic [SRC_W-1:0] SRC_PATH   = 3'd1;
    localparam logic [SRC_W-1:0] SRC_SYMBOL = 3'd2;
    localparam logic [SRC_W-1:0] SRC_GRAPH  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_VECTOR = 3'd4;

    localparam logic [STRAT_W-1:0] STRAT_RST = STRAT_WRECIP;
    localparam logic [LIM_W-1:0]   LIMIT_RST = 7'd64;
    localparam logic [WGT_W-1:0]   WGT_RST   = 16'd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_START,
        S_WAIT,
        S_UPDATE,
        S_SORT,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic mul1;
        logic mul2;
        logic calc_start;
        logic update;
        logic sort_init;
        logic scan_start;
        logic emit;
        logic batch_clear;
    } t_cmd;

    typedef struct packed {
        logic calc_busy;
        logic scan_busy;
        logic sort_more;
        logic out_free;
    } t_sts;

endpackage

/* rtl/rfk_ifs.sv */
// ----------------------------------------------------------------------------
// rank fusion channels
// hit input, result output and register write channels
// ----------------------------------------------------------------------------
interface rfk_hit_if;
    logic        valid;
    logic        ready;
    logic [63:0] doc_key;
    logic [2:0]  source_id;
    logic [9:0]  hit_rank;
    logic [15:0] hit_score;
    logic        has_hit;
    logic        batch_end;

    modport source (output valid, doc_key, source_id, hit_rank, hit_score, has_hit,
                    batch_end, input ready);
    modport sink (input valid, doc_key, source_id, hit_rank, hit_score, has_hit,
                  batch_end, output ready);
endinterface

interface rfk_res_if;
    logic               valid;
    logic               ready;
    logic [63:0]        out_key;
    logic signed [47:0] fused_score;
    logic               table_overflow;
    logic               final_result;

    modport source (output valid, out_key, fused_score, table_overflow, final_result,
                    input ready);
    modport sink (input valid, out_key, fused_score, table_overflow, final_result,
                  output ready);
endinterface

interface rfk_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rfk_ctrl.sv */
// ----------------------------------------------------------------------------
// rfk_ctrl
// sequencer: hit arithmetic, table lookup and update, then the sort passes
// ----------------------------------------------------------------------------
module rfk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_has_hit,
    input  logic          i_batch_end,
    output logic          o_ready,
    output rfk_pkg::t_cmd o_cmd,
    input  rfk_pkg::t_sts i_sts
);

    rfk_pkg::t_state r_state, n_state;
    logic            r_end, n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfk_pkg::S_IDLE;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            rfk_pkg::S_IDLE: begin
                // no transfer while reset is held
                o_ready = i_rst_n;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_end       = i_batch_end;
                    if (i_has_hit) begin
                        n_state = rfk_pkg::S_MUL1;
                    end else if (i_batch_end) begin
                        n_state = rfk_pkg::S_SORT;
                    end
                end
            end
            rfk_pkg::S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = rfk_pkg::S_MUL2;
            end
            rfk_pkg::S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = rfk_pkg::S_START;
            end
            rfk_pkg::S_START: begin
                // divider and key search run side by side
                o_cmd.calc_start = 1'b1;
                n_state          = rfk_pkg::S_WAIT;
            end
            rfk_pkg::S_WAIT: begin
                if (!i_sts.calc_busy) begin
                    n_state = rfk_pkg::S_UPDATE;
                end
            end
            rfk_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = r_end ? rfk_pkg::S_SORT : rfk_pkg::S_IDLE;
            end
            rfk_pkg::S_SORT: begin
                o_cmd.sort_init = 1'b1;
                n_state         = rfk_pkg::S_CHECK;
            end
            rfk_pkg::S_CHECK: begin
                if (i_sts.sort_more) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = rfk_pkg::S_SCAN;
                end else begin
                    o_cmd.batch_clear = 1'b1;
                    n_state           = rfk_pkg::S_IDLE;
                end
            end
            rfk_pkg::S_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = rfk_pkg::S_EMIT;
                end
            end
            rfk_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rfk_pkg::S_CHECK;
                end
            end
            default: begin
                n_state = rfk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rfk_dp.sv */
// ----------------------------------------------------------------------------
// rfk_dp
// registers, contribution arithmetic, key/score tables and selection scan
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfk_dp #(
    parameter int MAX_DOCS  = rfk_pkg::MAX_DOCS_DEF,
    parameter int FRAC_BITS = rfk_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rfk_pkg::t_cmd i_cmd,
    output rfk_pkg::t_sts o_sts,
    input  logic [63:0]   i_doc_key,
    input  logic [2:0]    i_source_id,
    input  logic [9:0]    i_hit_rank,
    input  logic [15:0]   i_hit_score,
    rfk_cfg_if.sink       i_cfg,
    rfk_res_if.source     o_res
);

    localparam int IW     = $clog2(MAX_DOCS);
    localparam int CW     = $clog2(MAX_DOCS + 1);
    localparam int NW     = (CW > rfk_pkg::LIM_W) ? CW : rfk_pkg::LIM_W;
    localparam int KW     = rfk_pkg::KEY_W;
    localparam int SW     = rfk_pkg::SCORE_W;
    localparam int DW     = rfk_pkg::DIV_W;
    localparam int EW     = rfk_pkg::DEN_W;
    localparam int DCNT_W = $clog2(rfk_pkg::DIV_W + 1);

    // alignment shifts per strategy, source fraction bits 29, 0, 14 and 30
    localparam int SH0_N = (FRAC_BITS >= 29) ? FRAC_BITS - 29 : 0;
    localparam int SH0_D = (FRAC_BITS >= 29) ? 0 : 29 - FRAC_BITS;
    localparam int SH2_N = FRAC_BITS - 14;
    localparam int SH3_N = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int SH3_D = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;

    localparam logic signed [SW+1:0] SAT_HI = {3'b000, {(SW-1){1'b1}}};
    localparam logic signed [SW+1:0] SAT_LO = {3'b111, {(SW-1){1'b0}}};

    // configuration registers
    logic [rfk_pkg::STRAT_W-1:0] r_strategy;
    logic [rfk_pkg::LIM_W-1:0]   r_limit;
    logic [15:0]                 r_w_text, r_w_path, r_w_symbol, r_w_graph, r_w_vector;

    // latched hit
    logic [KW-1:0]               r_key;
    logic [2:0]                  r_src;
    logic [9:0]                  r_rank;
    logic [15:0]                 r_hscore;
    logic [rfk_pkg::STRAT_W-1:0] r_strat;

    logic [26:0]   r_p1;
    logic [43:0]   r_p2;
    logic          r_neg;

    // divider
    logic [DW-1:0]     r_quo;
    logic [EW-1:0]     r_rem;
    logic [EW-1:0]     r_den;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_div_busy;

    // table state
    logic [KW-1:0]        key_mem   [MAX_DOCS];
    logic signed [SW-1:0] score_mem [MAX_DOCS];
    logic [KW-1:0]        r_rd_key;
    logic signed [SW-1:0] r_rd_score;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;

    // scan engine
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_pidx;
    logic          r_pv;
    logic          r_busy;
    logic          r_sort_mode;

    logic                 r_found;
    logic [IW-1:0]        r_fidx;
    logic signed [SW-1:0] r_fscore;

    logic                 r_best_vld;
    logic [KW-1:0]        r_best_key;
    logic signed [SW-1:0] r_best_score;
    logic                 r_prev_vld;
    logic [KW-1:0]        r_prev_key;
    logic signed [SW-1:0] r_prev_score;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_k;

    // output register
    logic                 r_out_vld;
    logic [KW-1:0]        r_out_key;
    logic signed [SW-1:0] r_out_score;
    logic                 r_out_ovf;
    logic                 r_out_final;

    logic [10:0]          w_d;
    logic                 w_rneg;
    logic [9:0]           w_mag;
    logic [15:0]          w_wgt;
    logic [27:0]          w_opnd;
    logic [DW-1:0]        w_num;
    logic [EW-1:0]        w_den;
    logic [EW:0]          w_rem_sh;
    logic                 w_ge;
    logic signed [SW:0]   w_c;
    logic signed [SW+1:0] w_sum;
    logic signed [SW-1:0] w_sat;
    logic                 w_full;
    logic                 w_we;
    logic [IW-1:0]        w_wa;
    logic [NW-1:0]        w_lim;
    logic [NW-1:0]        w_cnt_ext;
    logic [CW-1:0]        w_n;
    logic                 w_elig;
    logic                 w_better;
    logic                 w_out_free;

    function automatic logic ranks_before(input logic signed [SW-1:0] a_s,
                                          input logic [KW-1:0] a_k,
                                          input logic signed [SW-1:0] b_s,
                                          input logic [KW-1:0] b_k);
        if (a_s != b_s) begin
            return a_s > b_s;
        end
        return a_k < b_k;
    endfunction

    // no transfer while reset is held
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= rfk_pkg::STRAT_RST;
            r_limit    <= rfk_pkg::LIMIT_RST;
            r_w_text   <= rfk_pkg::WGT_RST;
            r_w_path   <= rfk_pkg::WGT_RST;
            r_w_symbol <= rfk_pkg::WGT_RST;
            r_w_graph  <= rfk_pkg::WGT_RST;
            r_w_vector <= rfk_pkg::WGT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rfk_pkg::REG_STRATEGY: r_strategy <= i_cfg.data[rfk_pkg::STRAT_W-1:0];
                rfk_pkg::REG_LIMIT:    r_limit    <= i_cfg.data[rfk_pkg::LIM_W-1:0];
                rfk_pkg::REG_W_TEXT:   r_w_text   <= i_cfg.data;
                rfk_pkg::REG_W_PATH:   r_w_path   <= i_cfg.data;
                rfk_pkg::REG_W_SYMBOL: r_w_symbol <= i_cfg.data;
                rfk_pkg::REG_W_GRAPH:  r_w_graph  <= i_cfg.data;
                rfk_pkg::REG_W_VECTOR: r_w_vector <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // contribution operands
    assign w_d    = 11'(rfk_pkg::RANK_BIAS) + {1'b0, r_rank};
    assign w_rneg = r_rank > 10'(rfk_pkg::BORDA_BASE);
    assign w_mag  = w_rneg ? r_rank - 10'(rfk_pkg::BORDA_BASE)
                           : 10'(rfk_pkg::BORDA_BASE) - r_rank;

    always_comb begin
        case (r_src)
            rfk_pkg::SRC_TEXT:   w_wgt = r_w_text;
            rfk_pkg::SRC_PATH:   w_wgt = r_w_path;
            rfk_pkg::SRC_SYMBOL: w_wgt = r_w_symbol;
            rfk_pkg::SRC_GRAPH:  w_wgt = r_w_graph;
            rfk_pkg::SRC_VECTOR: w_wgt = r_w_vector;
            default:             w_wgt = '0;
        endcase
    end

    always_comb begin
        case (r_strat)
            rfk_pkg::STRAT_WSUM:   w_opnd = 28'(r_hscore);
            rfk_pkg::STRAT_BORDA:  w_opnd = 28'(w_mag);
            rfk_pkg::STRAT_WRECIP: w_opnd = 28'(rfk_pkg::ONE_Q15) + 28'(r_p1);
            default:               w_opnd = '0;
        endcase
    end

    // dividend and divisor; the rounding half is added when the divider loads
    always_comb begin
        case (r_strat)
            rfk_pkg::STRAT_WSUM: begin
                w_num = DW'(r_p2) << SH0_N;
                w_den = EW'(1) << SH0_D;
            end
            rfk_pkg::STRAT_RRANK: begin
                w_num = DW'(1) << FRAC_BITS;
                w_den = EW'(w_d);
            end
            rfk_pkg::STRAT_BORDA: begin
                w_num = DW'(r_p2) << SH2_N;
                w_den = EW'(1);
            end
            default: begin
                w_num = DW'(r_p2) << SH3_N;
                w_den = EW'(w_d) << SH3_D;
            end
        endcase
    end

    assign w_rem_sh = {r_rem, r_quo[DW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key    <= i_doc_key;
            r_src    <= i_source_id;
            r_rank   <= i_hit_rank;
            r_hscore <= i_hit_score;
            r_strat  <= r_strategy;
        end
        if (i_cmd.mul1) begin
            r_p1 <= 27'(r_hscore) * 27'(w_d);
        end
        if (i_cmd.mul2) begin
            r_p2 <= 44'(w_wgt) * 44'(w_opnd);
        end
        if (i_cmd.calc_start) begin
            r_quo <= w_num + DW'(w_den >> 1);
            r_rem <= '0;
            r_den <= w_den;
            r_neg <= (r_strat == rfk_pkg::STRAT_BORDA) && w_rneg;
        end else if (r_div_busy) begin
            r_rem <= w_ge ? EW'(w_rem_sh - {1'b0, r_den}) : EW'(w_rem_sh);
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_dcnt     <= '0;
        end else if (i_cmd.calc_start) begin
            r_div_busy <= 1'b1;
            r_dcnt     <= DCNT_W'(DW);
        end else if (r_div_busy) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == DCNT_W'(1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // saturating accumulate
    assign w_c   = r_neg ? -$signed({1'b0, r_quo[SW-1:0]}) : $signed({1'b0, r_quo[SW-1:0]});
    assign w_sum = (r_found ? (SW+2)'(r_fscore) : '0) + (SW+2)'(w_c);
    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = SAT_HI[SW-1:0];
        end else if (w_sum < SAT_LO) begin
            w_sat = SAT_LO[SW-1:0];
        end else begin
            w_sat = w_sum[SW-1:0];
        end
    end

    assign w_full = r_count == CW'(MAX_DOCS);
    assign w_we   = i_cmd.update && (r_found || !w_full);
    assign w_wa   = r_found ? r_fidx : r_count[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            key_mem[w_wa]   <= r_key;
            score_mem[w_wa] <= w_sat;
        end
        r_rd_key   <= key_mem[r_idx[IW-1:0]];
        r_rd_score <= score_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.batch_clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.update && !r_found) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // scan engine: one table entry read per cycle, compared in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pv        <= 1'b0;
            r_idx       <= '0;
            r_sort_mode <= 1'b0;
        end else if (i_cmd.calc_start || i_cmd.scan_start) begin
            r_busy      <= 1'b1;
            r_pv        <= 1'b0;
            r_idx       <= '0;
            r_sort_mode <= i_cmd.scan_start;
        end else if (r_busy) begin
            if (r_idx < r_count) begin
                r_pidx <= r_idx[IW-1:0];
                r_pv   <= 1'b1;
                r_idx  <= r_idx + 1'b1;
            end else begin
                r_pv <= 1'b0;
                if (!r_pv) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign w_elig   = !r_prev_vld || ranks_before(r_prev_score, r_prev_key, r_rd_score, r_rd_key);
    assign w_better = !r_best_vld || ranks_before(r_rd_score, r_rd_key, r_best_score, r_best_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.calc_start) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_best_vld <= 1'b0;
        end else if (r_busy && r_pv) begin
            if (!r_sort_mode) begin
                if (r_rd_key == r_key) begin
                    r_found  <= 1'b1;
                    r_fidx   <= r_pidx;
                    r_fscore <= r_rd_score;
                end
            end else if (w_elig && w_better) begin
                r_best_vld   <= 1'b1;
                r_best_key   <= r_rd_key;
                r_best_score <= r_rd_score;
            end
        end
    end

    // result count for the batch
    assign w_lim     = (r_limit > rfk_pkg::LIM_W'(rfk_pkg::OUT_LIMIT))
                       ? NW'(rfk_pkg::OUT_LIMIT) : NW'(r_limit);
    assign w_cnt_ext = NW'(r_count);
    assign w_n       = (w_cnt_ext < w_lim) ? r_count : CW'(w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
            r_k        <= '0;
            r_n        <= '0;
        end else if (i_cmd.sort_init) begin
            r_prev_vld <= 1'b0;
            r_k        <= '0;
            r_n        <= w_n;
        end else if (i_cmd.emit) begin
            r_prev_vld   <= 1'b1;
            r_prev_key   <= r_best_key;
            r_prev_score <= r_best_score;
            r_k          <= r_k + 1'b1;
        end
    end

    assign w_out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_key   <= r_best_key;
            r_out_score <= r_best_score;
            r_out_ovf   <= r_ovf;
            r_out_final <= (r_k + 1'b1) == r_n;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.out_key        = r_out_key;
    assign o_res.fused_score    = r_out_score;
    assign o_res.table_overflow = r_out_ovf;
    assign o_res.final_result   = r_out_final;

    assign o_sts.calc_busy = r_div_busy || r_busy;
    assign o_sts.scan_busy = r_busy;
    assign o_sts.sort_more = r_k < r_n;
    assign o_sts.out_free  = w_out_free;

    `RFK_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_DOCS))
    `RFK_ASSERT_IMP(a_emit_ready, i_clk, i_rst_n, i_cmd.emit, w_out_free && r_best_vld)
    `RFK_ASSERT_NXT(a_batch_clear, i_clk, i_rst_n, i_cmd.batch_clear, r_count == '0 && !r_ovf)

endmodule

/* rtl/rank_fusion_top_k_top.sv */
// ----------------------------------------------------------------------------
// rank_fusion_top_k_top
// fuses ranked hits per document key and emits the best documents per batch
// ----------------------------------------------------------------------------
// i_hit takes one hit item per transfer; the item flagged batch_end closes the
// batch. o_res delivers the fused documents in descending score, ties to the
// smaller key, with final_result on the last one. i_cfg writes a register by
// index and is ready outside reset; write it only while the block is idle.
// One item is taken at a time. A hit runs two multiplies, then the bit-serial
// divider and the key search side by side, then the table update. A batch
// end then starts the sort, walks the table once per result and clears the
// table at the end. An item with no hit and no end is taken and does no more.
// Reset empties the table and loads the register defaults; no clearing pass.
// A stalled receiver holds the result register and the sort waits on it;
// nothing is dropped.
// ----------------------------------------------------------------------------
module rank_fusion_top_k_top #(
    parameter int MAX_DOCS  = rfk_pkg::MAX_DOCS_DEF,
    parameter int FRAC_BITS = rfk_pkg::FRAC_BITS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    rfk_hit_if.sink   i_hit,
    rfk_cfg_if.sink   i_cfg,
    rfk_res_if.source o_res
);

    rfk_pkg::t_cmd w_cmd;
    rfk_pkg::t_sts w_sts;

    rfk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_hit.valid),
        .i_has_hit   (i_hit.has_hit),
        .i_batch_end (i_hit.batch_end),
        .o_ready     (i_hit.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rfk_dp #(
        .MAX_DOCS  (MAX_DOCS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_doc_key   (i_hit.doc_key),
        .i_source_id (i_hit.source_id),
        .i_hit_rank  (i_hit.hit_rank),
        .i_hit_score (i_hit.hit_score),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule
